// ===== hw/rtl/rls_pkg.sv =====
`default_nettype none
package rls_pkg;

  localparam logic [30:0] LAMBDA_MIN = 31'd966367641;
  localparam logic [30:0] LAMBDA_MAX = 31'd1073741824;
  localparam logic [30:0] LAMBDA_RESET = 31'd1063004406;
  localparam logic [31:0] PINIT_RESET = 32'd6553600;

  localparam logic signed [47:0] P48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] P48_MIN = 48'sh8000_0000_0000;
  localparam logic signed [63:0] L48_HI = 64'sd140737488355327;
  localparam logic signed [63:0] L48_LO = -64'sd140737488355328;
  localparam logic signed [63:0] L32_HI = 64'sd2147483647;
  localparam logic signed [63:0] L32_LO = -64'sd2147483648;
  localparam logic signed [63:0] L25_HI = 64'sd16777215;
  localparam logic signed [63:0] L25_LO = -64'sd16777216;

  // divider: 49-bit magnitude shifted left by up to 32, quotient saturates at 47 bits
  localparam int DVD_W = 81;
  localparam int QW = 47;
  localparam int REG_IDX_W = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LAMBDA = 1'b0,
    REG_PINIT  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_WAIT,
    ST_DIV,
    ST_DIVWAIT,
    ST_OUT
  } st_t;

  typedef enum logic [2:0] {
    PH_PX,
    PH_XPX,
    PH_K,
    PH_Y,
    PH_W,
    PH_PU
  } ph_t;

  typedef struct packed {
    logic        start;
    logic [47:0] a;
    logic [47:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [95:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic        sh32;
    logic [48:0] num;
    logic [49:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

  function automatic logic [30:0] clamp_lambda(logic [30:0] ff);
    logic [30:0] r;
    r = ff;
    if (ff < LAMBDA_MIN) r = LAMBDA_MIN;
    if (ff > LAMBDA_MAX) r = LAMBDA_MAX;
    return r;
  endfunction

  function automatic logic signed [47:0] init_diag(logic [31:0] pd);
    logic [31:0] p;
    logic signed [47:0] r;
    p = (pd == 32'd0) ? 32'd1 : pd;
    if (p[31]) r = P48_MAX;
    else r = {p, 16'd0};
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > L48_HI) r = P48_MAX;
    else if (v < L48_LO) r = P48_MIN;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > L32_HI) r = 32'sh7FFF_FFFF;
    else if (v < L32_LO) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [24:0] sat25(logic signed [63:0] v);
    logic signed [24:0] r;
    if (v > L25_HI) r = 25'sh0FF_FFFF;
    else if (v < L25_LO) r = 25'sh100_0000;
    else r = v[24:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rls_in_if.sv =====
`default_nettype none
interface rls_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_in;
  logic signed [23:0] desired_in;
  logic               restart;

  modport source (output valid, sample_in, desired_in, restart, input ready);
  modport sink (input valid, sample_in, desired_in, restart, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rls_out_if.sv =====
`default_nettype none
interface rls_out_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] error_out;
  logic signed [24:0] filter_out;

  modport source (output valid, error_out, filter_out, input ready);
  modport sink (input valid, error_out, filter_out, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rls_mul.sv =====
`default_nettype none
module rls_mul (
  input  logic               clk,
  input  logic               rst,
  input  rls_pkg::mul_req_t  req,
  output rls_pkg::mul_rsp_t  rsp
);
  import rls_pkg::*;

  logic signed [47:0] a;
  logic signed [47:0] b;
  logic [1:0]         step;
  logic               busy;
  logic               done;
  logic signed [95:0] acc;
  logic signed [24:0] pa;
  logic signed [24:0] pb;
  logic signed [49:0] pp;
  logic signed [95:0] ppx;
  logic signed [95:0] ppsh;

  // four 25x25 partial products: lo*lo, hi*lo, lo*hi, hi*hi
  always_comb begin
    case (step)
      2'd0: begin
        pa = {1'b0, a[23:0]};
        pb = {1'b0, b[23:0]};
      end
      2'd1: begin
        pa = {a[47], a[47:24]};
        pb = {1'b0, b[23:0]};
      end
      2'd2: begin
        pa = {1'b0, a[23:0]};
        pb = {b[47], b[47:24]};
      end
      default: begin
        pa = {a[47], a[47:24]};
        pb = {b[47], b[47:24]};
      end
    endcase
    pp  = pa * pb;
    ppx = 96'(pp);
    case (step)
      2'd0:    ppsh = ppx;
      2'd1:    ppsh = ppx <<< 24;
      2'd2:    ppsh = ppx <<< 24;
      default: ppsh = ppx <<< 48;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= !req.start && busy && (step == 2'd3);
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a   <= req.a;
      b   <= req.b;
      acc <= '0;
    end else if (busy) begin
      acc <= acc + ppsh;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule
`default_nettype wire

// ===== hw/rtl/rls_div.sv =====
`default_nettype none
module rls_div (
  input  logic               clk,
  input  logic               rst,
  input  rls_pkg::div_req_t  req,
  output rls_pkg::div_rsp_t  rsp
);
  import rls_pkg::*;

  logic [DVD_W-1:0] dvd;
  logic [49:0]      dm;
  logic [49:0]      rem;
  logic [QW-1:0]    q;
  logic             ovf;
  logic             neg;
  logic             busy;
  logic             done;
  logic [6:0]       cnt;
  logic [48:0]      nm;
  logic [49:0]      dmag;
  logic [50:0]      rem_sh;
  logic             ge;
  logic [QW-1:0]    mag;

  always_comb begin
    nm     = req.num[48] ? (~req.num + 49'd1) : req.num;
    dmag   = req.den[49] ? (~req.den + 50'd1) : req.den;
    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dm};
    mag    = ovf ? {QW{1'b1}} : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && (cnt == 7'd0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd0) begin
        busy <= 1'b0;
      end
    end
  end

  // restoring division, one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.sh32 ? {nm, 32'd0} : {2'd0, nm, 30'd0};
      dm  <= dmag;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      neg <= req.num[48] ^ req.den[49];
      cnt <= 7'(DVD_W - 1);
    end else if (busy) begin
      rem <= ge ? 50'(rem_sh - {1'b0, dm}) : rem_sh[49:0];
      dvd <= dvd << 1;
      q   <= {q[QW-2:0], ge};
      if (ge && cnt >= 7'(QW)) ovf <= 1'b1;
      cnt <= cnt - 7'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? (48'd0 - {1'b0, mag}) : {1'b0, mag};

endmodule
`default_nettype wire

// ===== hw/rtl/rls_adaptive_fir.sv =====
`default_nettype none
// Channel    Modport   Payload                              Transaction
// samples    sink      sample_in, desired_in, restart       valid & ready
// results    source    error_out, filter_out                valid & ready
// wr_*       input     wr_index, wr_data                    wr_en
//
// The P update dominates: per entry one multiply and one bit-serial divide,
// with P read from and written back to a single-port memory.
// After reset and for each restart item, a clearing pass reloads P;
// samples.ready is low meanwhile.
// A finished result waits in the output register; the next item is taken meanwhile.
module rls_adaptive_fir #(
  parameter int ORDER = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [rls_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [31:0]                     wr_data,
  rls_in_if.sink                          samples,
  rls_out_if.source                       results
);
  import rls_pkg::*;

  localparam int IW = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int PDEPTH = ORDER * ORDER;
  localparam int AW = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int SW = 50 + $clog2(ORDER + 1);
  localparam int YW = 56 + $clog2(ORDER + 1);
  localparam logic [IW-1:0] ILAST = IW'(ORDER - 1);
  localparam logic [AW-1:0] ALAST = AW'(PDEPTH - 1);

  st_t state, state_next;
  ph_t phase;

  logic [30:0]        lambda_reg;
  logic [31:0]        pinit_reg;
  logic signed [47:0] diag;
  logic               from_item;
  logic [IW-1:0]      i;
  logic [IW-1:0]      j;
  logic [AW-1:0]      addr;

  logic signed [23:0] xs  [ORDER];
  logic signed [31:0] ws  [ORDER];
  logic signed [47:0] pxs [ORDER];
  logic signed [47:0] ks  [ORDER];

  logic signed [23:0]   desired;
  logic signed [SW-1:0] sacc;
  logic signed [YW-1:0] yacc;
  logic signed [47:0]   xpx;
  logic signed [47:0]   preg;
  logic signed [48:0]   diff;
  logic signed [24:0]   es;
  logic signed [24:0]   ys;
  logic                 ovalid;
  logic signed [24:0]   oerr;
  logic signed [24:0]   ofilt;

  logic [47:0] pmem [PDEPTH];
  logic [47:0] prd;
  logic        pwe;
  logic [47:0] pwd;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [IW-1:0]        xi;
  logic [IW-1:0]        pxi;
  logic signed [23:0]   xsel;
  logic signed [24:0]   x2;
  logic signed [47:0]   pxsel;
  logic signed [31:0]   wsel;
  logic signed [47:0]   ksel;
  logic [30:0]          lam;
  logic signed [49:0]   den_raw;
  logic signed [49:0]   den;
  logic signed [95:0]   prod;
  logic signed [47:0]   quo;
  logic signed [SW-1:0] s_sum;
  logic signed [YW-1:0] ysum;
  logic signed [YW-25:0] yv;
  logic signed [63:0]   ev;
  logic signed [31:0]   wnew;
  logic signed [47:0]   kp;
  logic signed [48:0]   diffv;

  rls_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  rls_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    xi      = (phase == PH_PX) ? j : i;
    pxi     = (phase == PH_PU) ? j : i;
    xsel    = xs[xi];
    x2      = {xsel, 1'b0};
    pxsel   = pxs[pxi];
    wsel    = ws[i];
    ksel    = ks[i];
    lam     = clamp_lambda(lambda_reg);
    den_raw = $signed({17'd0, lam, 2'b00}) + 50'(xpx);
    den     = (den_raw == 50'sd0) ? 50'sd1 : den_raw;
    prod    = mrsp.prod;
    quo     = drsp.quo;
    s_sum   = sacc + SW'(prod >>> 24);
    ysum    = yacc + YW'(prod);
    yv      = ysum[YW-1:24];
    ev      = 64'(desired) - 64'(yv);
    wnew    = sat32(64'(wsel) + 64'(prod >>> 31));
    kp      = sat48(64'(prod >>> 32));
    diffv   = 49'(preg) - 49'(kp);
  end

  always_comb begin
    mreq.start = (state == ST_MUL);
    case (phase)
      PH_PX: begin
        mreq.a = prd;
        mreq.b = 48'(x2);
      end
      PH_XPX: begin
        mreq.a = pxsel;
        mreq.b = 48'(x2);
      end
      PH_Y: begin
        mreq.a = 48'(wsel);
        mreq.b = 48'(xsel);
      end
      PH_W: begin
        mreq.a = ksel;
        mreq.b = 48'(es);
      end
      default: begin
        mreq.a = ksel;
        mreq.b = pxsel;
      end
    endcase

    dreq.start = (state == ST_DIV);
    if (phase == PH_K) begin
      dreq.sh32 = 1'b1;
      dreq.num  = 49'(pxsel);
      dreq.den  = den;
    end else begin
      dreq.sh32 = 1'b0;
      dreq.num  = diff;
      dreq.den  = {19'd0, lam};
    end

    pwe = (state == ST_CLEAR) || (state == ST_DIVWAIT && phase == PH_PU && drsp.done);
    pwd = (state == ST_CLEAR) ? ((i == j) ? diag : 48'd0) : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (addr == ALAST) state_next = from_item ? ST_READ : ST_IDLE;
      end
      ST_IDLE: begin
        if (samples.valid) state_next = samples.restart ? ST_CLEAR : ST_READ;
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (mrsp.done) begin
          case (phase)
            PH_PX:   state_next = (addr == ALAST) ? ST_MUL : ST_READ;
            PH_XPX:  state_next = (i == ILAST) ? ST_DIV : ST_MUL;
            PH_Y:    state_next = ST_MUL;
            PH_W:    state_next = (i == ILAST) ? ST_READ : ST_MUL;
            PH_PU:   state_next = ST_DIV;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: state_next = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (drsp.done) begin
          if (phase == PH_K) state_next = (i == ILAST) ? ST_MUL : ST_DIV;
          else state_next = (addr == ALAST) ? ST_OUT : ST_READ;
        end
      end
      ST_OUT: begin
        if (!ovalid || results.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // P memory; in the P update each entry is read, then written back before the next read
  always_ff @(posedge clk) begin
    if (pwe) pmem[addr] <= pwd;
    prd <= pmem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PX;
      i          <= '0;
      j          <= '0;
      addr       <= '0;
      from_item  <= 1'b0;
      ovalid     <= 1'b0;
      lambda_reg <= LAMBDA_RESET;
      pinit_reg  <= PINIT_RESET;
      diag       <= init_diag(PINIT_RESET);
      for (int n = 0; n < ORDER; n++) begin
        xs[n] <= '0;
        ws[n] <= '0;
      end
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_LAMBDA: lambda_reg <= wr_data[30:0];
          REG_PINIT:  pinit_reg  <= wr_data;
          default: ;
        endcase
      end
      if (results.ready && state != ST_OUT) ovalid <= 1'b0;
      if (state == ST_MUL) preg <= prd;

      case (state)
        ST_CLEAR: begin
          if (addr == ALAST) begin
            i     <= '0;
            j     <= '0;
            addr  <= '0;
            phase <= PH_PX;
            sacc  <= '0;
          end else begin
            if (j == ILAST) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            addr <= addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (samples.valid) begin
            desired   <= samples.desired_in;
            from_item <= 1'b1;
            diag      <= init_diag(pinit_reg);
            xs[0]     <= samples.sample_in;
            for (int n = 1; n < ORDER; n++) begin
              xs[n] <= samples.restart ? 24'sd0 : xs[n-1];
            end
            if (samples.restart) begin
              for (int n = 0; n < ORDER; n++) ws[n] <= '0;
            end
            i     <= '0;
            j     <= '0;
            addr  <= '0;
            sacc  <= '0;
            phase <= PH_PX;
          end
        end
        ST_WAIT: begin
          if (mrsp.done) begin
            case (phase)
              PH_PX: begin
                if (j == ILAST) begin
                  pxs[i] <= sat48(64'(s_sum));
                  sacc   <= '0;
                end else begin
                  sacc <= s_sum;
                end
                if (addr == ALAST) begin
                  phase <= PH_XPX;
                  i     <= '0;
                  j     <= '0;
                  addr  <= '0;
                end else begin
                  if (j == ILAST) begin
                    j <= '0;
                    i <= i + 1'b1;
                  end else begin
                    j <= j + 1'b1;
                  end
                  addr <= addr + 1'b1;
                end
              end
              PH_XPX: begin
                if (i == ILAST) begin
                  xpx   <= sat48(64'(s_sum));
                  phase <= PH_K;
                  i     <= '0;
                end else begin
                  sacc <= s_sum;
                  i    <= i + 1'b1;
                end
              end
              PH_Y: begin
                if (i == ILAST) begin
                  ys    <= sat25(64'(yv));
                  es    <= sat25(ev);
                  phase <= PH_W;
                  i     <= '0;
                end else begin
                  yacc <= ysum;
                  i    <= i + 1'b1;
                end
              end
              PH_W: begin
                ws[i] <= wnew;
                if (i == ILAST) begin
                  phase <= PH_PU;
                  i     <= '0;
                  j     <= '0;
                  addr  <= '0;
                end else begin
                  i <= i + 1'b1;
                end
              end
              PH_PU: diff <= diffv;
              default: ;
            endcase
          end
        end
        ST_DIVWAIT: begin
          if (drsp.done) begin
            if (phase == PH_K) begin
              ks[i] <= quo;
              if (i == ILAST) begin
                phase <= PH_Y;
                i     <= '0;
                yacc  <= '0;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              if (addr == ALAST) begin
                i    <= '0;
                j    <= '0;
                addr <= '0;
              end else begin
                if (j == ILAST) begin
                  j <= '0;
                  i <= i + 1'b1;
                end else begin
                  j <= j + 1'b1;
                end
                addr <= addr + 1'b1;
              end
            end
          end
        end
        ST_OUT: begin
          if (!ovalid || results.ready) begin
            ovalid <= 1'b1;
            oerr   <= es;
            ofilt  <= ys;
          end
        end
        default: ;
      endcase
    end
  end

  assign samples.ready      = (state == ST_IDLE);
  assign results.valid      = ovalid;
  assign results.error_out  = oerr;
  assign results.filter_out = ofilt;

endmodule
`default_nettype wire

// ===== hw/rtl/rls_chk.sv =====
`default_nettype none
module rls_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [24:0] error_out,
  input logic [24:0] filter_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(error_out) && $stable(filter_out))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_clear_pass: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input ready during clearing pass");

endmodule

bind rls_adaptive_fir rls_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (samples.valid),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .error_out  (results.error_out),
  .filter_out (results.filter_out)
);
`default_nettype wire
